// ----- rtl/core/websocket_frame_deframer_macros.svh -----
// ----------------------------------------------------------------------------
// websocket frame deframer assertion macros
// concurrent property wrappers clocked on aclk, off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define WSFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_CLOSE = 4'h8;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_PAY  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       data_valid;
        logic [3:0] message_opcode;
        logic       end_of_message;
        logic       orphan_error;
        logic       closed;
    } result_t;

endpackage

// ----- rtl/core/wsfd_parser.sv -----
// ----------------------------------------------------------------------------
// wsfd_parser
// frame header state machine, payload counter and unmasking for one stream
// ----------------------------------------------------------------------------
module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    phase_t      phase_reg,        phase_next;
    logic        final_reg,        final_next;
    logic [3:0]  frame_op_reg,     frame_op_next;
    logic        masked_reg,       masked_next;
    logic [3:0]  ext_left_reg,     ext_left_next;
    logic [63:0] pay_left_reg,     pay_left_next;
    logic [31:0] key_reg,          key_next;
    logic [1:0]  key_pos_reg,      key_pos_next;
    logic        msg_open_reg,     msg_open_next;
    logic [3:0]  open_op_reg,      open_op_next;
    logic        stopped_reg,      stopped_next;

    logic        hdr_done;
    logic [3:0]  ext_dec;
    logic [1:0]  key_pos_inc;
    logic [63:0] pay_dec;
    logic [7:0]  key_byte;

    assign ext_dec     = ext_left_reg - 4'd1;
    assign key_pos_inc = key_pos_reg + 2'd1;
    assign pay_dec     = pay_left_reg - 64'd1;

    always_comb begin
        case (key_pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        final_next    = final_reg;
        frame_op_next = frame_op_reg;
        masked_next   = masked_reg;
        ext_left_next = ext_left_reg;
        pay_left_next = pay_left_reg;
        key_next      = key_reg;
        key_pos_next  = key_pos_reg;
        msg_open_next = msg_open_reg;
        open_op_next  = open_op_reg;
        stopped_next  = stopped_reg;
        hdr_done      = 1'b0;
        result        = '0;

        if (step && !stopped_reg) begin
            unique case (phase_reg)
                PH_HDR0: begin
                    final_next    = rx_byte[7];
                    frame_op_next = rx_byte[3:0];
                    phase_next    = PH_HDR1;
                end
                PH_HDR1: begin
                    masked_next   = rx_byte[7];
                    key_next      = '0;
                    key_pos_next  = '0;
                    pay_left_next = '0;
                    if (rx_byte[6:0] == LEN_EXT16) begin
                        ext_left_next = EXT16_BYTES;
                        phase_next    = PH_EXT;
                    end else if (rx_byte[6:0] == LEN_EXT64) begin
                        ext_left_next = EXT64_BYTES;
                        phase_next    = PH_EXT;
                    end else begin
                        pay_left_next = {57'd0, rx_byte[6:0]};
                        if (rx_byte[7]) begin
                            phase_next = PH_KEY;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    pay_left_next = {pay_left_reg[55:0], rx_byte};
                    ext_left_next = ext_dec;
                    if (ext_dec == 4'd0) begin
                        if (masked_reg) begin
                            key_pos_next = '0;
                            phase_next   = PH_KEY;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                PH_KEY: begin
                    key_next     = {key_reg[23:0], rx_byte};
                    key_pos_next = key_pos_inc;
                    if (key_pos_inc == 2'd0) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_PAY: begin
                    key_pos_next          = key_pos_inc;
                    pay_left_next         = pay_dec;
                    result.valid          = 1'b1;
                    result.data_byte      = rx_byte ^ key_byte;
                    result.data_valid     = 1'b1;
                    result.message_opcode = open_op_reg;
                    if (pay_dec == 64'd0) begin
                        phase_next = PH_HDR0;
                        if (final_reg || frame_op_reg == OP_CLOSE) begin
                            result.end_of_message = 1'b1;
                            msg_open_next         = 1'b0;
                            if (final_reg && open_op_reg == OP_CLOSE) begin
                                result.closed = 1'b1;
                                stopped_next  = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase

            // header complete: flag an orphan continuation, or open or join the message, then payload or frame end
            if (hdr_done) begin
                key_pos_next = '0;
                if (!msg_open_reg && frame_op_reg == OP_CONT) begin
                    stopped_next        = 1'b1;
                    phase_next          = PH_HDR0;
                    result.valid        = 1'b1;
                    result.orphan_error = 1'b1;
                    result.closed       = 1'b1;
                end else begin
                    if (!msg_open_reg) begin
                        msg_open_next = 1'b1;
                        open_op_next  = frame_op_reg;
                    end
                    if (pay_left_next == 64'd0) begin
                        phase_next = PH_HDR0;
                        if (final_reg || frame_op_reg == OP_CLOSE) begin
                            result.valid          = 1'b1;
                            result.end_of_message = 1'b1;
                            result.message_opcode = open_op_next;
                            msg_open_next         = 1'b0;
                            if (final_reg && open_op_next == OP_CLOSE) begin
                                result.closed = 1'b1;
                                stopped_next  = 1'b1;
                            end
                        end
                    end else begin
                        phase_next = PH_PAY;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            final_reg    <= 1'b0;
            frame_op_reg <= '0;
            masked_reg   <= 1'b0;
            ext_left_reg <= '0;
            pay_left_reg <= '0;
            key_reg      <= '0;
            key_pos_reg  <= '0;
            msg_open_reg <= 1'b0;
            open_op_reg  <= '0;
            stopped_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            final_reg    <= final_next;
            frame_op_reg <= frame_op_next;
            masked_reg   <= masked_next;
            ext_left_reg <= ext_left_next;
            pay_left_reg <= pay_left_next;
            key_reg      <= key_next;
            key_pos_reg  <= key_pos_next;
            msg_open_reg <= msg_open_next;
            open_op_reg  <= open_op_next;
            stopped_reg  <= stopped_next;
        end
    end

endmodule

// ----- rtl/core/websocket_frame_deframer.sv -----
// Receives one connection's byte stream and strips websocket framing: each
// accepted byte is a header byte or a payload byte, and every payload byte
// leaves unmasked with the opcode of its message, while end of message, a
// stray continuation frame and a finished close are flagged on the result.
// The block takes one byte per clock cycle while the output is not held by
// m_ready low; each byte passes through the input register and then the
// result register, and the header parser with its 64-bit payload counter
// sits between them. After an orphan continuation frame or a completed
// close message the block drops all further bytes until reset.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// input register, frame parser and result register with valid/ready channels
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer
    import wsfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_data_valid,
    output logic [3:0] m_message_opcode,
    output logic       m_end_of_message,
    output logic       m_orphan_error,
    output logic       m_closed
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       m_valid_reg;
    result_t    out_reg;
    result_t    res;
    logic       advance;
    logic       step;

    assign advance = !m_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    wsfd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= step && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_data_byte      = out_reg.data_byte;
    assign m_data_valid     = out_reg.data_valid;
    assign m_message_opcode = out_reg.message_opcode;
    assign m_end_of_message = out_reg.end_of_message;
    assign m_orphan_error   = out_reg.orphan_error;
    assign m_closed         = out_reg.closed;

    // a result without a payload byte only reports a frame end or an orphan
    `WSFD_ASSERT_NOW(a_no_empty_result, m_valid && !m_data_valid,
        m_end_of_message || m_orphan_error, "result carries neither data nor event")
    `WSFD_ASSERT_NOW(a_orphan_closes, m_valid && m_orphan_error, m_closed,
        "orphan error without closed")
    // input side only stalls when both registers are full and output is blocked
    `WSFD_ASSERT_NOW(a_stall_cause, !s_ready, in_valid_reg && m_valid && !m_ready,
        "input stalled without a full pipeline")
    `WSFD_ASSERT_NEXT(a_silent_after_close, m_valid && m_ready && m_closed, !m_valid,
        "result produced after close")

endmodule
